// ----- src/multi_pattern_byte_matcher_core_defines.svh -----
// Assertion macros shared by the multi-pattern byte matcher RTL.
`ifndef MULTI_PATTERN_BYTE_MATCHER_CORE_DEFINES_SVH
`define MULTI_PATTERN_BYTE_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MPBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MPBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mpbm_pkg.sv -----
// Types and constants of the multi-pattern byte matcher.
`timescale 1ns / 1ps
package mpbm_pkg;

  localparam int unsigned MatchNodeW = 10;
  localparam int unsigned LenW       = 8;
  localparam int unsigned OffW       = 16;

  typedef enum logic [1:0] {
    CmdAdd     = 2'd0,
    CmdPrepare = 2'd1,
    CmdScan    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StRejected = 3'd1,
    StNoRoom   = 3'd2,
    StMatch    = 3'd3,
    StNoMatch  = 3'd4,
    StTooLong  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FailNone    = 2'd0,
    FailNoRoom  = 2'd1,
    FailTooLong = 2'd2
  } ins_fail_e;

  typedef enum logic [4:0] {
    SClear,
    SIdle,
    SAddRd,
    SAddChk,
    SAddEndRd,
    SAddEndWr,
    SPrepNextU,
    SPrepLoadU,
    SPrepFailU,
    SPrepRdGoto,
    SPrepChkGoto,
    SPrepWalkRd,
    SPrepWalkChk,
    SPrepWalkFail,
    SPrepTgtRd,
    SPrepTgtCap,
    SPrepNodeWr,
    SPrepNextC,
    SScanRd,
    SScanChk,
    SScanFail,
    SScanHit,
    SScanDepth,
    SEmit
  } fsm_e;

endpackage

// ----- src/mpbm_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module mpbm_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/multi_pattern_byte_matcher_core.sv -----
// Top level of the multi-pattern byte matcher: sequencer around the trie memories.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o  cmd_i, data_byte_i, last_i
// out       source     out_valid_o/out_stall_i status_o, offset_o, match_node_o,
//                                             match_length_o
// cfg       sink       cfg_we_i               cfg_wdata_i (case_sensitive)
//
// One word is taken at a time; the input stalls until the work for that word is done. A
// rejected or failed add byte is answered without a table read; an accepted one reads
// the goto table and, when it ends a pattern on a node that already exists, also
// updates that node. A scan byte reads the goto table and follows fail links as needed,
// then reports a match, or a no-match result on the last byte of the chunk; a byte
// dropped after a match gives no result. A prepare walks every node and all 256 byte
// codes of each node, plus the fail walk of every child.
// After reset a clearing pass zeroes the goto table and the node table; no word is
// taken meanwhile, configuration writes are.
// A result waits in the output register while out_stall_i is high.
module multi_pattern_byte_matcher_core
  import mpbm_pkg::*;
#(
  parameter int unsigned MAX_STATES      = 1024,
  parameter int unsigned MAX_PATTERN_LEN = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            cmd_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic [OffW-1:0]       offset_o,
  output logic [MatchNodeW-1:0] match_node_o,
  output logic [LenW-1:0]       match_length_o
);

  `include "multi_pattern_byte_matcher_core_defines.svh"

  // Node index width, pattern position width and goto address width.
  localparam int unsigned NW = $clog2(MAX_STATES);
  localparam int unsigned PW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned GW = NW + 8;

  // Node table word: fail link, output link, end flag, depth.
  localparam int unsigned DepLsb  = 0;
  localparam int unsigned EndBit  = LenW;
  localparam int unsigned OutLsb  = LenW + 1;
  localparam int unsigned FailLsb = LenW + 1 + NW;
  localparam int unsigned NodeWW  = LenW + 1 + 2 * NW;

  function automatic logic [NodeWW-1:0] node_word(logic [NW-1:0] f, logic [NW-1:0] o,
                                                  logic e, logic [LenW-1:0] d);
    node_word = {f, o, e, d};
  endfunction

  fsm_e            state_q, state_d;
  logic [GW-1:0]   clr_q, clr_d;
  logic            case_q, case_d;
  logic [NW:0]     ncount_q, ncount_d;
  logic [NW-1:0]   cursor_q, cursor_d;
  logic [PW-1:0]   ipos_q, ipos_d;
  ins_fail_e       ifail_q, ifail_d;
  logic            prep_q, prep_d;
  logic [NW-1:0]   scan_q, scan_d;
  logic [NW-1:0]   start_q, start_d;
  logic [OffW-1:0] coff_q, coff_d;
  logic            matched_q, matched_d;
  logic [7:0]      ch_q, ch_d;
  logic            last_q, last_d;
  logic [NW-1:0]   u_q, u_d, fu_q, fu_d, v_q, v_d, f_q, f_d, g_q, g_d, outv_q, outv_d;
  logic [NW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [7:0]      c_q, c_d;
  status_e         pst_q, pst_d;
  logic [OffW-1:0] poff_q, poff_d;
  logic [NW-1:0]   pnode_q, pnode_d;
  logic [LenW-1:0] plen_q, plen_d;
  logic            ovalid_q, ovalid_d;
  status_e         ost_q, ost_d;
  logic [OffW-1:0] ooff_q, ooff_d;
  logic [NW-1:0]   onode_q, onode_d;
  logic [LenW-1:0] olen_q, olen_d;

  logic              g_we;
  logic [GW-1:0]     g_waddr, g_raddr;
  logic [NW-1:0]     g_wdata, g_rdata;
  logic              n_we;
  logic [NW-1:0]     n_waddr, n_raddr;
  logic [NodeWW-1:0] n_wdata, n_rdata;
  logic              q_we;
  logic [NW-1:0]     q_waddr, q_raddr, q_wdata, q_rdata;

  logic              in_acc;
  logic [7:0]        fold_byte;
  logic [NW-1:0]     hit;

  mpbm_ram #(.Width(NW), .Depth(MAX_STATES * 256)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );

  mpbm_ram #(.Width(NodeWW), .Depth(MAX_STATES)) u_node (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .raddr_i(n_raddr), .rdata_o(n_rdata)
  );

  mpbm_ram #(.Width(NW), .Depth(MAX_STATES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  assign in_stall_o = (state_q != SIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  // ASCII upper case folds to lower case unless the block compares exactly.
  assign fold_byte  = (!case_q && data_byte_i >= 8'h41 && data_byte_i <= 8'h5A)
                      ? data_byte_i + 8'd32 : data_byte_i;
  // Output node reached from the node just entered: itself if it ends a pattern.
  assign hit        = n_rdata[EndBit] ? g_q : n_rdata[OutLsb +: NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      clr_q     <= '0;
      case_q    <= 1'b0;
      ncount_q  <= (NW + 1)'(1);
      cursor_q  <= '0;
      ipos_q    <= '0;
      ifail_q   <= FailNone;
      prep_q    <= 1'b0;
      scan_q    <= '0;
      start_q   <= '0;
      coff_q    <= '0;
      matched_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      case_q    <= case_d;
      ncount_q  <= ncount_d;
      cursor_q  <= cursor_d;
      ipos_q    <= ipos_d;
      ifail_q   <= ifail_d;
      prep_q    <= prep_d;
      scan_q    <= scan_d;
      start_q   <= start_d;
      coff_q    <= coff_d;
      matched_q <= matched_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    last_q  <= last_d;
    u_q     <= u_d;
    fu_q    <= fu_d;
    v_q     <= v_d;
    f_q     <= f_d;
    g_q     <= g_d;
    outv_q  <= outv_d;
    c_q     <= c_d;
    pst_q   <= pst_d;
    poff_q  <= poff_d;
    pnode_q <= pnode_d;
    plen_q  <= plen_d;
    ost_q   <= ost_d;
    ooff_q  <= ooff_d;
    onode_q <= onode_d;
    olen_q  <= olen_d;
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    case_d    = cfg_we_i ? cfg_wdata_i : case_q;
    ncount_d  = ncount_q;
    cursor_d  = cursor_q;
    ipos_d    = ipos_q;
    ifail_d   = ifail_q;
    prep_d    = prep_q;
    scan_d    = scan_q;
    start_d   = start_q;
    coff_d    = coff_q;
    matched_d = matched_q;
    ch_d      = ch_q;
    last_d    = last_q;
    u_d       = u_q;
    fu_d      = fu_q;
    v_d       = v_q;
    f_d       = f_q;
    g_d       = g_q;
    outv_d    = outv_q;
    head_d    = head_q;
    tail_d    = tail_q;
    c_d       = c_q;
    pst_d     = pst_q;
    poff_d    = poff_q;
    pnode_d   = pnode_q;
    plen_d    = plen_q;
    ovalid_d  = ovalid_q && out_stall_i;
    ost_d     = ost_q;
    ooff_d    = ooff_q;
    onode_d   = onode_q;
    olen_d    = olen_q;
    g_we      = 1'b0;
    g_waddr   = {cursor_q, ch_q};
    g_wdata   = '0;
    g_raddr   = {f_q, ch_q};
    n_we      = 1'b0;
    n_waddr   = v_q;
    n_wdata   = '0;
    n_raddr   = v_q;
    q_we      = 1'b0;
    q_waddr   = tail_q;
    q_wdata   = v_q;
    q_raddr   = head_q;

    unique case (state_q)
      SClear: begin
        g_we    = 1'b1;
        g_waddr = clr_q;
        if (clr_q < GW'(MAX_STATES)) begin
          n_we    = 1'b1;
          n_waddr = clr_q[NW-1:0];
        end
        clr_d = clr_q + GW'(1);
        if (clr_q == GW'(MAX_STATES * 256 - 1)) begin
          state_d = SIdle;
        end
      end

      SIdle: begin
        if (in_acc) begin
          ch_d   = fold_byte;
          last_d = last_i;
          pst_d  = StOk;
          poff_d = '0;
          pnode_d = '0;
          plen_d = '0;
          unique case (cmd_i)
            CmdAdd: begin
              if (prep_q) begin
                pst_d   = StRejected;
                state_d = SEmit;
              end else if (ifail_q != FailNone ||
                           ipos_q >= PW'(MAX_PATTERN_LEN)) begin
                // A failed pattern keeps answering its failure until its last byte.
                pst_d = (ifail_q == FailNoRoom) ? StNoRoom : StTooLong;
                ifail_d = (ifail_q == FailNone) ? FailTooLong : ifail_q;
                if (last_i) begin
                  cursor_d = '0;
                  ipos_d   = '0;
                  ifail_d  = FailNone;
                end
                state_d = SEmit;
              end else begin
                state_d = SAddRd;
              end
            end
            CmdPrepare: begin
              if (!prep_q) begin
                cursor_d = '0;
                ipos_d   = '0;
                ifail_d  = FailNone;
                // The root goes first, then the walk queue in order.
                u_d      = '0;
                fu_d     = '0;
                c_d      = '0;
                head_d   = '0;
                tail_d   = '0;
                state_d  = SPrepRdGoto;
              end else begin
                state_d = SEmit;
              end
            end
            CmdScan: begin
              if (!prep_q) begin
                pst_d   = StRejected;
                state_d = SEmit;
              end else if (matched_q) begin
                // Bytes after a match in the chunk are dropped.
                if (last_i) begin
                  start_d   = scan_q;
                  coff_d    = '0;
                  matched_d = 1'b0;
                end
              end else begin
                f_d     = scan_q;
                state_d = SScanRd;
              end
            end
            default: begin
            end
          endcase
        end
      end

      SAddRd: begin
        g_raddr = {cursor_q, ch_q};
        state_d = SAddChk;
      end

      SAddChk: begin
        state_d = SEmit;
        if (g_rdata == '0) begin
          if (ncount_q >= (NW + 1)'(MAX_STATES)) begin
            pst_d = StNoRoom;
            if (last_q) begin
              cursor_d = '0;
              ipos_d   = '0;
              ifail_d  = FailNone;
            end else begin
              ifail_d = FailNoRoom;
            end
          end else begin
            // New child; a last byte marks it as a pattern end at once.
            g_we     = 1'b1;
            g_waddr  = {cursor_q, ch_q};
            g_wdata  = ncount_q[NW-1:0];
            n_we     = 1'b1;
            n_waddr  = ncount_q[NW-1:0];
            n_wdata  = node_word('0, '0, last_q, LenW'(ipos_q + PW'(1)));
            ncount_d = ncount_q + (NW + 1)'(1);
            if (last_q) begin
              cursor_d = '0;
              ipos_d   = '0;
            end else begin
              cursor_d = ncount_q[NW-1:0];
              ipos_d   = ipos_q + PW'(1);
            end
          end
        end else if (last_q) begin
          cursor_d = g_rdata;
          state_d  = SAddEndRd;
        end else begin
          cursor_d = g_rdata;
          ipos_d   = ipos_q + PW'(1);
        end
      end

      SAddEndRd: begin
        n_raddr = cursor_q;
        state_d = SAddEndWr;
      end

      SAddEndWr: begin
        n_we     = 1'b1;
        n_waddr  = cursor_q;
        n_wdata  = n_rdata | (NodeWW'(1) << EndBit);
        cursor_d = '0;
        ipos_d   = '0;
        ifail_d  = FailNone;
        state_d  = SEmit;
      end

      SPrepNextU: begin
        if (head_q == tail_q) begin
          prep_d    = 1'b1;
          scan_d    = '0;
          start_d   = '0;
          coff_d    = '0;
          matched_d = 1'b0;
          state_d   = SEmit;
        end else begin
          q_raddr = head_q;
          head_d  = head_q + NW'(1);
          state_d = SPrepLoadU;
        end
      end

      SPrepLoadU: begin
        u_d     = q_rdata;
        n_raddr = q_rdata;
        state_d = SPrepFailU;
      end

      SPrepFailU: begin
        fu_d    = n_rdata[FailLsb +: NW];
        c_d     = '0;
        state_d = SPrepRdGoto;
      end

      SPrepRdGoto: begin
        g_raddr = {u_q, c_q};
        state_d = SPrepChkGoto;
      end

      SPrepChkGoto: begin
        if (g_rdata == '0) begin
          state_d = SPrepNextC;
        end else begin
          v_d     = g_rdata;
          f_d     = fu_q;
          state_d = SPrepWalkRd;
        end
      end

      SPrepWalkRd: begin
        g_raddr = {f_q, c_q};
        state_d = SPrepWalkChk;
      end

      SPrepWalkChk: begin
        if (g_rdata != '0 || f_q == '0) begin
          // A child of the root fails back to the root itself.
          g_d     = (g_rdata == v_q) ? '0 : g_rdata;
          state_d = SPrepTgtRd;
        end else begin
          n_raddr = f_q;
          state_d = SPrepWalkFail;
        end
      end

      SPrepWalkFail: begin
        f_d     = n_rdata[FailLsb +: NW];
        state_d = SPrepWalkRd;
      end

      SPrepTgtRd: begin
        n_raddr = g_q;
        state_d = SPrepTgtCap;
      end

      SPrepTgtCap: begin
        outv_d  = hit;
        n_raddr = v_q;
        state_d = SPrepNodeWr;
      end

      SPrepNodeWr: begin
        n_we    = 1'b1;
        n_waddr = v_q;
        n_wdata = node_word(g_q, outv_q, n_rdata[EndBit], n_rdata[DepLsb +: LenW]);
        q_we    = 1'b1;
        q_waddr = tail_q;
        q_wdata = v_q;
        tail_d  = tail_q + NW'(1);
        state_d = SPrepNextC;
      end

      SPrepNextC: begin
        if (c_q == 8'hFF) begin
          state_d = SPrepNextU;
        end else begin
          c_d     = c_q + 8'd1;
          state_d = SPrepRdGoto;
        end
      end

      SScanRd: begin
        g_raddr = {f_q, ch_q};
        state_d = SScanChk;
      end

      SScanChk: begin
        if (f_q != '0 && g_rdata == '0) begin
          n_raddr = f_q;
          state_d = SScanFail;
        end else begin
          g_d     = g_rdata;
          n_raddr = g_rdata;
          state_d = SScanHit;
        end
      end

      SScanFail: begin
        f_d     = n_rdata[FailLsb +: NW];
        state_d = SScanRd;
      end

      SScanHit: begin
        if (hit != '0) begin
          v_d     = hit;
          n_raddr = hit;
          state_d = SScanDepth;
        end else begin
          scan_d  = g_q;
          state_d = SIdle;
          if (coff_q != '1) begin
            coff_d = coff_q + OffW'(1);
          end
          if (last_q) begin
            start_d = g_q;
            coff_d  = '0;
            pst_d   = StNoMatch;
            state_d = SEmit;
          end
        end
      end

      SScanDepth: begin
        // First match of the chunk: report it and rewind to the chunk start.
        pst_d     = StMatch;
        poff_d    = coff_q;
        pnode_d   = v_q;
        plen_d    = n_rdata[DepLsb +: LenW];
        matched_d = !last_q;
        scan_d    = start_q;
        if (last_q) begin
          coff_d = '0;
        end
        state_d = SEmit;
      end

      SEmit: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          ost_d    = pst_q;
          ooff_d   = poff_q;
          onode_d  = pnode_q;
          olen_d   = plen_q;
          state_d  = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign out_valid_o    = ovalid_q;
  assign status_o       = ost_q;
  assign offset_o       = ooff_q;
  assign match_node_o   = MatchNodeW'(onode_q);
  assign match_length_o = olen_q;

  `MPBM_ASSERT_NOW(a_no_accept_in_clear, state_q == SClear, in_stall_o, "word taken while clearing")
  `MPBM_ASSERT_NOW(a_node_count_bound, 1'b1, ncount_q <= (NW + 1)'(MAX_STATES), "trie overfull")
  `MPBM_ASSERT_NEXT(a_prepared_sticky, prep_q, prep_q, "prepared flag dropped")
  `MPBM_ASSERT_NOW(a_match_needs_prep, matched_q, prep_q, "chunk match before prepare")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the multi-pattern byte matcher core.
`timescale 1ns / 1ps
module tb
  import mpbm_pkg::*;
;

  localparam int unsigned NumStates = 1024;
  localparam int unsigned MaxLen    = 255;
  localparam longint      CycleCap  = 64'd8_000_000;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
    bit         last;
  } word_t;

  typedef struct {
    status_e     st;
    logic [15:0] off;
    logic [9:0]  node;
    logic [7:0]  len;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = 2'd0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] offset_o;
  logic [9:0]  match_node_o;
  logic [7:0]  match_length_o;

  multi_pattern_byte_matcher_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .offset_o       (offset_o),
    .match_node_o   (match_node_o),
    .match_length_o (match_length_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Words waiting to be sent and results the matcher still owes us.
  word_t   word_q[$];
  result_t owed_q[$];
  int      errors = 0;
  int      send_idle = 0;
  int      recv_stall = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  longint  cycles = 0;

  // Shadow copy of the automaton.
  bit [9:0]    goto_t[NumStates * 256];
  bit [9:0]    fail_l[NumStates];
  bit [9:0]    out_l[NumStates];
  bit          end_f[NumStates];
  bit [7:0]    dep[NumStates];
  int unsigned n_nodes = 1;
  int unsigned ins_cur = 0;
  int unsigned ins_pos = 0;
  ins_fail_e   ins_fail = FailNone;
  bit          prepared = 0;
  bit          case_exact = 0;
  int unsigned scan_st = 0;
  int unsigned start_st = 0;
  int unsigned chunk_off = 0;
  bit          matched = 0;

  // Breadth-first walk that sets fail and output links of every node.
  task automatic link_trie();
    int unsigned walk[$];
    int unsigned u, v, f, g;
    fail_l[0] = 0;
    out_l[0]  = 0;
    for (int c = 0; c < 256; c++) begin
      v = goto_t[c];
      if (v != 0) begin
        fail_l[v] = 0;
        out_l[v]  = 0;
        walk = {walk, v};
      end
    end
    while (walk.size() > 0) begin
      u = walk.pop_front();
      for (int c = 0; c < 256; c++) begin
        v = goto_t[u * 256 + c];
        if (v != 0) begin
          f = fail_l[u];
          while (f != 0 && goto_t[f * 256 + c] == 0) f = fail_l[f];
          g = goto_t[f * 256 + c];
          if (g == v) g = 0;
          fail_l[v] = 10'(g);
          out_l[v]  = end_f[g] ? 10'(g) : out_l[g];
          walk = {walk, v};
        end
      end
    end
  endtask

  // Queues one word and works out what the matcher should answer to it.
  task automatic send_word(logic [1:0] cmd, logic [7:0] b, bit lst);
    word_t       w;
    result_t     r;
    int unsigned c, v, nd, hit;
    w.cmd  = cmd;
    w.data = b;
    w.last = lst;
    word_q = {word_q, w};
    c = b;
    if (!case_exact && c >= 65 && c <= 90) c += 32;
    r.st = StOk;
    r.off = '0;
    r.node = '0;
    r.len = '0;
    if (cmd == CmdAdd) begin
      if (prepared) begin
        r.st = StRejected;
      end else begin
        if (ins_fail == FailNone) begin
          if (ins_pos >= MaxLen) begin
            ins_fail = FailTooLong;
          end else begin
            v = goto_t[ins_cur * 256 + c];
            if (v == 0) begin
              if (n_nodes >= NumStates) begin
                ins_fail = FailNoRoom;
              end else begin
                v = n_nodes;
                n_nodes++;
                goto_t[ins_cur * 256 + c] = 10'(v);
                dep[v] = 8'(ins_pos + 1);
              end
            end
            if (ins_fail == FailNone) begin
              ins_cur = v;
              ins_pos++;
            end
          end
        end
        if (ins_fail == FailNoRoom) r.st = StNoRoom;
        else if (ins_fail == FailTooLong) r.st = StTooLong;
        if (lst) begin
          if (ins_fail == FailNone) end_f[ins_cur] = 1;
          ins_cur  = 0;
          ins_pos  = 0;
          ins_fail = FailNone;
        end
      end
      owed_q = {owed_q, r};
    end else if (cmd == CmdPrepare) begin
      if (!prepared) begin
        ins_cur  = 0;
        ins_pos  = 0;
        ins_fail = FailNone;
        link_trie();
        prepared  = 1;
        scan_st   = 0;
        start_st  = 0;
        chunk_off = 0;
        matched   = 0;
      end
      owed_q = {owed_q, r};
    end else if (cmd == CmdScan) begin
      if (!prepared) begin
        r.st = StRejected;
        owed_q = {owed_q, r};
      end else begin
        if (!matched) begin
          nd = scan_st;
          while (nd != 0 && goto_t[nd * 256 + c] == 0) nd = fail_l[nd];
          v = goto_t[nd * 256 + c];
          hit = end_f[v] ? v : out_l[v];
          if (hit != 0) begin
            r.st   = StMatch;
            r.off  = chunk_off[15:0];
            r.node = hit[9:0];
            r.len  = dep[hit];
            owed_q = {owed_q, r};
            matched = 1;
            scan_st = start_st;
          end else begin
            scan_st = v;
            if (chunk_off < 65535) chunk_off++;
            if (lst) begin
              r.st = StNoMatch;
              owed_q = {owed_q, r};
            end
          end
        end
        if (lst) begin
          start_st  = scan_st;
          chunk_off = 0;
          matched   = 0;
        end
      end
    end
  endtask

  task automatic send_pattern(string s, logic [1:0] cmd);
    for (int i = 0; i < s.len(); i++) send_word(cmd, s[i], i == s.len() - 1);
  endtask

  // Scan bytes come mostly from the letters of the patterns so matches are common.
  task automatic send_chunks(int n_words);
    string       letters;
    int          len;
    logic [7:0]  b;
    letters = "abcdehirsuABCDEHIRSU";
    while (n_words > 0) begin
      if ($urandom_range(99) < 6) begin
        case ($urandom_range(2))
          0: send_word(2'd3, 8'($urandom_range(255)), 1'($urandom_range(1)));
          1: send_word(CmdAdd, 8'($urandom_range(255)), 1'($urandom_range(1)));
          default: send_word(CmdPrepare, 8'($urandom_range(255)), 1'($urandom_range(1)));
        endcase
        n_words--;
      end else begin
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
          else b = letters[$urandom_range(letters.len() - 1)];
          send_word(CmdScan, b, i == len - 1);
        end
        n_words -= len;
      end
    end
  endtask

  // Waits until every word is taken and answered, then lets a scan finish.
  task automatic settle();
    wait (word_q.size() == 0 && owed_q.size() == 0);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic write_case(bit v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case_exact = v;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Sender: holds a word until it is taken, then may idle before the next.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) void'(word_q.pop_front());
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i  <= 1'b1;
          cmd_i       <= word_q[0].cmd;
          data_byte_i <= word_q[0].data;
          last_i      <= word_q[0].last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the result side, counted here.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stalls at random and checks each result word in order.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          report("unexpected result status", 32'(status_o), 32'd0);
        end else begin
          want = owed_q.pop_front();
          if (status_o != want.st) report("status", status_o, want.st);
          if (offset_o != want.off) report("offset", offset_o, want.off);
          if (match_node_o != want.node) report("match_node", match_node_o, want.node);
          if (match_length_o != want.len) report("match_length", match_length_o, want.len);
        end
      end
      out_stall_i <= (hold_left > 1) || ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_case(1'b0);

    // Scanning before the automaton exists is refused.
    send_word(CmdScan, "a", 1'b1);
    // Upper case folds into the same nodes while folding is on.
    send_pattern("She", CmdAdd);
    send_pattern("he", CmdAdd);
    send_pattern("HIS", CmdAdd);
    send_pattern("hers", CmdAdd);
    send_pattern("abc", CmdAdd);
    send_pattern("bcd", CmdAdd);
    send_pattern("cab", CmdAdd);
    send_pattern("d", CmdAdd);
    send_pattern("ba", CmdAdd);
    settle();
    write_case(1'b1);
    send_pattern("Ab", CmdAdd);
    send_pattern("uR", CmdAdd);
    settle();
    write_case(1'b0);

    // One pattern of high bytes overruns the length limit; the nodes it made
    // stay as plain prefixes.
    for (int i = 0; i < 257; i++)
      send_word(CmdAdd, 8'($urandom_range(255, 128)), i == 256);
    send_pattern("zz", CmdAdd);
    send_pattern("ab", CmdAdd);
    send_word(CmdPrepare, 8'hff, 1'b1);
    send_word(CmdPrepare, 8'h00, 1'b0);
    send_word(CmdAdd, "x", 1'b1);
    send_pattern("ushers", CmdScan);
    send_pattern("xyz", CmdScan);
    send_pattern("D", CmdScan);
    send_word(2'd3, 8'h55, 1'b1);
    send_word(CmdScan, 8'h00, 1'b0);
    send_word(CmdScan, "d", 1'b1);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_case(ph[0]);
      @(negedge clk_i);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  hold_req++; end
        1: begin send_idle = 70; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 70; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      send_chunks(45);
      settle();
    end
    write_case(1'b1);
    @(negedge clk_i);
    send_idle  = 0;
    recv_stall = 0;
    send_chunks(20);
    settle();

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/mpbm_pkg.sv
src/mpbm_ram.sv
src/multi_pattern_byte_matcher_core.sv
sim/tb.sv
